// ===== hdl/kvt_pkg.sv =====
`default_nettype none

package kvt_pkg;

    // default geometry
    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // fixed widths of the transaction fields
    localparam int FIELD_BITS = 32;
    localparam int OP_BITS    = 3;
    localparam int CNT_BITS   = 6;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_COUNT  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_DUP  = 2'd2,
        STAT_MISS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_BITS-1:0]    opcode;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
    } in_t;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [FIELD_BITS-1:0] read_value;
        logic [CNT_BITS-1:0]   match_count;
        logic [CNT_BITS-1:0]   entry_count;
    } out_t;

endpackage

`default_nettype wire

// ===== hdl/kvt_store.sv =====
`default_nettype none

module kvt_store
    import kvt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                  aclk,
    input  wire logic [AW-1:0]         rd_addr,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [KEY_BITS-1:0]   wr_key,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    output logic      [KEY_BITS-1:0]   rd_key,
    output logic      [VALUE_BITS-1:0] rd_value
);

    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];

    // one write port, shared by insert and erase compaction
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    // registered read, both arrays at the same address
    always_ff @(posedge aclk) begin
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/kvt_engine.sv =====
`default_nettype none

module kvt_engine
    import kvt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire in_t                   cmd,
    output logic                       idle,
    output logic                       done,
    input  wire logic                  take,
    output out_t                       res,
    output logic      [AW-1:0]         rd_addr,
    input  wire logic [KEY_BITS-1:0]   rd_key,
    input  wire logic [VALUE_BITS-1:0] rd_value,
    output logic                       wr_en,
    output logic      [AW-1:0]         wr_addr,
    output logic      [KEY_BITS-1:0]   wr_key,
    output logic      [VALUE_BITS-1:0] wr_value
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = (KEY_BITS > FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int RW = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int WW = (CW > CNT_BITS) ? CW : CNT_BITS;

    state_t                state_reg, state_next;
    opcode_t               op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         issue_reg, issue_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]         cmp_pos_reg, cmp_pos_next;
    status_t               status_reg, status_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] rdv_reg, rdv_next;
    logic [CNT_BITS-1:0]   match_reg, match_next;

    logic [KW-1:0]         key_w;
    logic [RW-1:0]         val_w;
    logic [RW-1:0]         rdv_w;
    logic [WW-1:0]         fill_w;
    logic [CW-1:0]         pos_dec;
    logic                  hit;
    logic                  scan_end;

    // narrow incoming fields to the stored widths
    assign key_w = KW'(cmd.key);
    assign val_w = RW'(cmd.value);

    // shared compare unit: key match, or value match when counting
    assign hit = cmp_vld_reg &&
                 ((op_reg == OP_COUNT) ? (rd_value == val_reg) : (rd_key == key_reg));
    assign scan_end = !cmp_vld_reg && (issue_reg >= fill_reg);
    assign pos_dec  = cmp_pos_reg - CW'(1);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // operand and result registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        issue_reg   <= issue_next;
        cmp_pos_reg <= cmp_pos_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        rdv_reg     <= rdv_next;
        match_reg   <= match_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        fill_next    = fill_reg;
        issue_next   = issue_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_pos_next = cmp_pos_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        rdv_next     = rdv_reg;
        match_next   = match_reg;
        rd_addr      = issue_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = fill_reg[AW-1:0];
        wr_key       = key_reg;
        wr_value     = val_reg;
        idle         = 1'b0;
        done         = 1'b0;

        // walk pointer: one read per cycle while entries remain
        if (state_reg == S_SCAN || state_reg == S_SHIFT) begin
            if (issue_reg < fill_reg) begin
                issue_next   = issue_reg + CW'(1);
                cmp_vld_next = 1'b1;
                cmp_pos_next = issue_reg;
            end else begin
                cmp_vld_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    op_next      = opcode_t'(cmd.opcode);
                    key_next     = key_w[KEY_BITS-1:0];
                    val_next     = val_w[VALUE_BITS-1:0];
                    issue_next   = '0;
                    cmp_vld_next = 1'b0;
                    status_next  = STAT_OK;
                    found_next   = 1'b0;
                    rdv_next     = '0;
                    match_next   = '0;
                    case (cmd.opcode)
                        OP_INSERT: begin
                            if (fill_reg >= CW'(ENTRIES)) begin
                                status_next = STAT_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_ERASE, OP_LOOKUP, OP_COUNT: begin
                            state_next = S_SCAN;
                        end
                        OP_CLEAR: begin
                            fill_next  = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                unique case (op_reg)
                    OP_COUNT: begin
                        if (hit && match_reg != CNT_MAX) begin
                            match_next = match_reg + CNT_BITS'(1);
                        end
                        if (scan_end) begin
                            state_next = S_DONE;
                        end
                    end
                    OP_INSERT: begin
                        if (hit) begin
                            status_next = STAT_DUP;
                            state_next  = S_DONE;
                        end else if (scan_end) begin
                            wr_en      = 1'b1;
                            fill_next  = fill_reg + CW'(1);
                            state_next = S_DONE;
                        end
                    end
                    OP_LOOKUP: begin
                        if (hit) begin
                            found_next = 1'b1;
                            rdv_next   = rd_value;
                            state_next = S_DONE;
                        end else if (scan_end) begin
                            status_next = STAT_MISS;
                            state_next  = S_DONE;
                        end
                    end
                    OP_ERASE: begin
                        if (hit) begin
                            found_next   = 1'b1;
                            issue_next   = cmp_pos_reg + CW'(1);
                            cmp_vld_next = 1'b0;
                            state_next   = S_SHIFT;
                        end else if (scan_end) begin
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SHIFT: begin
                // entry read last cycle moves up one place
                if (cmp_vld_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_dec[AW-1:0];
                    wr_key   = rd_key;
                    wr_value = rd_value;
                end
                if (scan_end) begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                done = 1'b1;
                if (take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result assembly with saturated entry count
    assign rdv_w  = RW'(rdv_reg);
    assign fill_w = WW'(fill_reg);

    always_comb begin
        res.status      = status_reg;
        res.found       = found_reg;
        res.read_value  = rdv_w[FIELD_BITS-1:0];
        res.match_count = match_reg;
        if (fill_w > WW'(CNT_MAX)) begin
            res.entry_count = CNT_MAX;
        end else begin
            res.entry_count = fill_w[CNT_BITS-1:0];
        end
    end

    // table never holds more than its capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(ENTRIES))
        else $error("fill count above capacity");

    // store is written only while walking the table
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_SCAN || state_reg == S_SHIFT))
        else $error("store write outside scan or shift");

    // compaction never moves the head entry
    a_shift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && cmp_vld_reg) |-> (cmp_pos_reg != '0))
        else $error("shift source at entry zero");

    // fill count only changes on the way out of a walk or on clear
    a_fill_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_next != fill_reg) |-> (state_next == S_DONE))
        else $error("fill count changed mid operation");

endmodule

`default_nettype wire

// ===== hdl/keyed_value_table_unit.sv =====
`default_nettype none

// channel  direction  payload  handshake
// s_       in         in_t     s_valid / s_ready
// m_       out        out_t    m_valid / m_ready
//
// clear and unused opcodes go from accept straight to the done state.
// insert, lookup, count: the table is walked through the single store read
// port, one entry per cycle; lookup and a rejected insert stop at the
// matching entry, and a full table rejects an insert without a walk.
// an erase that finds its key walks on to the end, moving each entry behind
// the erased one up through the same read and write port. the next
// transaction is taken in the cycle after the result register loads.
// reset (aresetn low, synchronous) empties the table; store contents are
// left as they are. s_ready is low while an operation runs and while a
// finished result waits for a full output register.

module keyed_value_table_unit
    import kvt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                  eng_idle;
    logic                  eng_done;
    logic                  eng_take;
    out_t                  eng_res;
    logic [AW-1:0]         rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_value;
    logic                  out_valid_reg;
    out_t                  out_data_reg;

    assign s_ready  = eng_idle;
    assign eng_take = eng_done && (!out_valid_reg || m_ready);

    kvt_engine #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .cmd      (s_data),
        .idle     (eng_idle),
        .done     (eng_done),
        .take     (eng_take),
        .res      (eng_res),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value)
    );

    kvt_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_store (
        .aclk     (aclk),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // output register decouples the result transaction from the engine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (eng_take) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_take) begin
            out_data_reg <= eng_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
